// ===== hw/rtl/tpts_pkg.sv =====
`default_nettype none
package tpts_pkg;

    localparam int DIM_W     = 11;
    localparam int CFG_IDX_W = 3;
    localparam int DIVD_W    = 10;
    localparam int DIV_CNT_W = 4;
    localparam int TEXEL_W   = 32;
    localparam int ADDR_W    = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_PADDED_WIDTH  = 3'd2,
        CFG_PADDED_HEIGHT = 3'd3,
        CFG_TEXEL_SIZE    = 3'd4
    } cfg_index_t;

    localparam logic       OP_LOAD = 1'b0;
    localparam logic       OP_EMIT = 1'b1;

    localparam logic [1:0] TEXEL_8BIT  = 2'd0;
    localparam logic [1:0] TEXEL_16BIT = 2'd1;

    localparam logic [3:0] ZORDER_QUAD [4][4] = '{
        '{4'd0,  4'd1,  4'd4,  4'd5},
        '{4'd2,  4'd3,  4'd6,  4'd7},
        '{4'd8,  4'd9,  4'd12, 4'd13},
        '{4'd10, 4'd11, 4'd14, 4'd15}
    };

    typedef struct packed {
        logic             done;
        logic [DIM_W-1:0] rem_x;
        logic [DIM_W-1:0] rem_y;
    } div_res_t;

    function automatic logic [5:0] zorder_offset(input logic [2:0] tx, input logic [2:0] ty);
        return {ty[2], tx[2], ZORDER_QUAD[ty[1:0]][tx[1:0]]};
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tpts_cmd_if.sv =====
`default_nettype none
interface tpts_cmd_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [13:0] texel_index;
    logic [31:0] texel_value;
    logic [6:0]  tile_column;
    logic [6:0]  tile_row;

    modport source (
        output valid, opcode, texel_index, texel_value, tile_column, tile_row,
        input  ready
    );
    modport sink (
        input  valid, opcode, texel_index, texel_value, tile_column, tile_row,
        output ready
    );
endinterface
`default_nettype wire

// ===== hw/rtl/tpts_rsp_if.sv =====
`default_nettype none
interface tpts_rsp_if;
    logic        valid;
    logic        ready;
    logic [19:0] out_address;
    logic [31:0] out_texel;
    logic        last_of_tile;

    modport source (
        output valid, out_address, out_texel, last_of_tile,
        input  ready
    );
    modport sink (
        input  valid, out_address, out_texel, last_of_tile,
        output ready
    );
endinterface
`default_nettype wire

// ===== hw/rtl/tpts_wrap_div.sv =====
`default_nettype none
// Serial restoring remainder for both tile origin coordinates, one bit per cycle.
module tpts_wrap_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [tpts_pkg::DIVD_W-1:0]   dividend_x,
    input  wire logic [tpts_pkg::DIVD_W-1:0]   dividend_y,
    input  wire logic [tpts_pkg::DIM_W-1:0]    divisor_x,
    input  wire logic [tpts_pkg::DIM_W-1:0]    divisor_y,
    output tpts_pkg::div_res_t                 res
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [tpts_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [tpts_pkg::DIVD_W-1:0]    nx_reg;
    logic [tpts_pkg::DIVD_W-1:0]    ny_reg;
    logic [tpts_pkg::DIM_W-1:0]     rx_reg;
    logic [tpts_pkg::DIM_W-1:0]     ry_reg;
    logic [tpts_pkg::DIM_W:0]       trial_x;
    logic [tpts_pkg::DIM_W:0]       trial_y;
    logic [tpts_pkg::DIM_W-1:0]     rx_next;
    logic [tpts_pkg::DIM_W-1:0]     ry_next;

    always_comb
    begin
        trial_x = {rx_reg, nx_reg[tpts_pkg::DIVD_W-1]};
        trial_y = {ry_reg, ny_reg[tpts_pkg::DIVD_W-1]};
        if (trial_x >= {1'b0, divisor_x})
        begin
            rx_next = tpts_pkg::DIM_W'(trial_x - {1'b0, divisor_x});
        end
        else
        begin
            rx_next = tpts_pkg::DIM_W'(trial_x);
        end
        if (trial_y >= {1'b0, divisor_y})
        begin
            ry_next = tpts_pkg::DIM_W'(trial_y - {1'b0, divisor_y});
        end
        else
        begin
            ry_next = tpts_pkg::DIM_W'(trial_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= tpts_pkg::DIV_CNT_W'(tpts_pkg::DIVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == tpts_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nx_reg <= dividend_x;
            ny_reg <= dividend_y;
            rx_reg <= '0;
            ry_reg <= '0;
        end
        else if (busy_reg)
        begin
            nx_reg <= {nx_reg[tpts_pkg::DIVD_W-2:0], 1'b0};
            ny_reg <= {ny_reg[tpts_pkg::DIVD_W-2:0], 1'b0};
            rx_reg <= rx_next;
            ry_reg <= ry_next;
        end
    end

    assign res.done  = done_reg;
    assign res.rem_x = rx_reg;
    assign res.rem_y = ry_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/texture_pad_and_tile_swizzle.sv =====
// Texture pad and 8x8 Z-order tile swizzle.
// cmd channel (valid/ready): opcode load writes texel_value to the source store at
// texel_index (indexes at or above STORE_DEPTH are dropped); opcode emit asks for
// tile (tile_column, tile_row) of the padded texture.
// rsp channel (valid/ready): 64 items per emit, row-major inside the tile, each with
// the Z-order destination address, the wrapped and byte-swapped source texel and
// last_of_tile on the 64th.
// cfg port: cfg_wr_en, cfg_index, cfg_data; write only while the block is idle.
// An emit first runs the serial remainder unit (tile origin modulo source size), then
// sets up the row base and tile product, then reads one texel per cycle from the
// single-port store while rsp is not stalled.
// cmd is accepted only in idle, entered once a tile's last read is issued. A stalled rsp
// holds its item and the store read pipeline freezes behind it; nothing is lost.
// Reset clears control state and restores the register defaults; store contents
// are undefined until loaded and no clearing pass is run.
`default_nettype none
module texture_pad_and_tile_swizzle #(
    parameter int STORE_DEPTH = 16384
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    tpts_cmd_if.sink                              cmd,
    tpts_rsp_if.source                            rsp,
    input  wire logic                             cfg_wr_en,
    input  wire logic [tpts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tpts_pkg::DIM_W-1:0]       cfg_data
);

    localparam int AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int DW    = tpts_pkg::DIM_W;
    localparam int RB_W  = 2 * DW;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_MUL, S_WALK} state_t;

    state_t             state_reg;
    logic [DW-1:0]      src_w_reg;
    logic [DW-1:0]      src_h_reg;
    logic [DW-1:0]      pad_w_reg;
    logic [DW-1:0]      pad_h_reg;
    logic [1:0]         tsize_reg;

    logic [6:0]         col_reg;
    logic [6:0]         row_reg;
    logic [DW-1:0]      sx0_reg;
    logic [DW-1:0]      sx_reg;
    logic [DW-1:0]      sy_reg;
    logic [RB_W-1:0]    row_base_reg;
    logic [15:0]        tile_prod_reg;
    logic [5:0]         cnt_reg;

    logic               p1_valid_reg;
    logic               p1_last_reg;
    logic               p1_inrange_reg;
    logic [19:0]        p1_addr_reg;
    logic [31:0]        mem_q_reg;

    logic               out_valid_reg;
    logic               out_last_reg;
    logic [19:0]        out_addr_reg;
    logic [31:0]        out_texel_reg;

    logic [31:0]        store_mem [STORE_DEPTH];

    tpts_pkg::div_res_t div_res;

    logic               cmd_acc;
    logic               emit_start;
    logic               mem_we;
    logic [DW-1:0]      sw_eff;
    logic [DW-1:0]      sh_eff;
    logic [8:0]         tiles_per_row;
    logic               walking;
    logic               move_p1;
    logic               issue;
    logic [DW-1:0]      sx_inc;
    logic [DW-1:0]      sy_inc;
    logic [RB_W:0]      src_idx;
    logic               src_inrange;
    logic [16:0]        tile_num;
    logic [19:0]        dst_addr;
    logic [31:0]        texel_fmt;

    assign cmd.ready     = (state_reg == S_IDLE);
    assign cmd_acc       = cmd.valid && cmd.ready;
    assign emit_start    = cmd_acc && (cmd.opcode == tpts_pkg::OP_EMIT);
    assign mem_we        = cmd_acc && (cmd.opcode == tpts_pkg::OP_LOAD)
                           && (32'(cmd.texel_index) < 32'(STORE_DEPTH));
    assign sw_eff        = (src_w_reg == '0) ? DW'(1) : src_w_reg;
    assign sh_eff        = (src_h_reg == '0) ? DW'(1) : src_h_reg;
    assign tiles_per_row = 9'(({1'b0, pad_w_reg} + 12'd7) >> 3);
    assign walking       = (state_reg == S_WALK);
    assign move_p1       = p1_valid_reg && (!out_valid_reg || rsp.ready);
    assign issue         = walking && (!p1_valid_reg || move_p1);
    assign sx_inc        = sx_reg + 1'b1;
    assign sy_inc        = sy_reg + 1'b1;
    assign src_idx       = {1'b0, row_base_reg} + (RB_W+1)'(sx_reg);
    assign src_inrange   = (32'(src_idx) < 32'(STORE_DEPTH));
    assign tile_num      = {1'b0, tile_prod_reg} + 17'(col_reg);
    assign dst_addr      = {tile_num[13:0], tpts_pkg::zorder_offset(cnt_reg[2:0], cnt_reg[5:3])};

    tpts_wrap_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (emit_start),
        .dividend_x ({cmd.tile_column, 3'b000}),
        .dividend_y ({cmd.tile_row, 3'b000}),
        .divisor_x  (sw_eff),
        .divisor_y  (sh_eff),
        .res        (div_res)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[AW'(cmd.texel_index)] <= cmd.texel_value;
        end
        if (issue)
        begin
            mem_q_reg <= store_mem[AW'(src_idx)];
        end
    end

    always_comb
    begin
        case (tsize_reg)
            tpts_pkg::TEXEL_8BIT:
            begin
                texel_fmt = {24'd0, mem_q_reg[7:0]};
            end
            tpts_pkg::TEXEL_16BIT:
            begin
                texel_fmt = {16'd0, mem_q_reg[7:0], mem_q_reg[15:8]};
            end
            default:
            begin
                texel_fmt = {mem_q_reg[7:0], mem_q_reg[15:8], mem_q_reg[23:16],
                             mem_q_reg[31:24]};
            end
        endcase
        if (!p1_inrange_reg)
        begin
            texel_fmt = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            src_w_reg     <= DW'(8);
            src_h_reg     <= DW'(8);
            pad_w_reg     <= DW'(8);
            pad_h_reg     <= DW'(8);
            tsize_reg     <= 2'd2;
            cnt_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    tpts_pkg::CFG_SOURCE_WIDTH:  src_w_reg <= cfg_data;
                    tpts_pkg::CFG_SOURCE_HEIGHT: src_h_reg <= cfg_data;
                    tpts_pkg::CFG_PADDED_WIDTH:  pad_w_reg <= cfg_data;
                    tpts_pkg::CFG_PADDED_HEIGHT: pad_h_reg <= cfg_data;
                    tpts_pkg::CFG_TEXEL_SIZE:    tsize_reg <= cfg_data[1:0];
                    default:
                    begin
                    end
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (emit_start)
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_res.done)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    if (issue)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == 6'd63)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (issue)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (move_p1)
            begin
                p1_valid_reg <= 1'b0;
            end

            if (move_p1)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // walk datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (emit_start)
        begin
            col_reg <= cmd.tile_column;
            row_reg <= cmd.tile_row;
        end
        if ((state_reg == S_DIV) && div_res.done)
        begin
            sx0_reg <= div_res.rem_x;
            sx_reg  <= div_res.rem_x;
            sy_reg  <= div_res.rem_y;
        end
        if (state_reg == S_MUL)
        begin
            row_base_reg  <= RB_W'(sy_reg) * RB_W'(sw_eff);
            tile_prod_reg <= 16'(row_reg) * 16'(tiles_per_row);
        end
        if (issue)
        begin
            p1_addr_reg    <= dst_addr;
            p1_last_reg    <= (cnt_reg == 6'd63);
            p1_inrange_reg <= src_inrange;
            if (cnt_reg[2:0] == 3'd7)
            begin
                sx_reg <= sx0_reg;
                if (sy_inc == sh_eff)
                begin
                    sy_reg       <= '0;
                    row_base_reg <= '0;
                end
                else
                begin
                    sy_reg       <= sy_inc;
                    row_base_reg <= row_base_reg + RB_W'(sw_eff);
                end
            end
            else
            begin
                sx_reg <= (sx_inc == sw_eff) ? '0 : sx_inc;
            end
        end
        if (move_p1)
        begin
            out_addr_reg  <= p1_addr_reg;
            out_texel_reg <= texel_fmt;
            out_last_reg  <= p1_last_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.out_address  = out_addr_reg;
    assign rsp.out_texel    = out_texel_reg;
    assign rsp.last_of_tile = out_last_reg;

`ifndef SYNTHESIS
    a_wrap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        walking |-> (sx_reg < sw_eff) && (sy_reg < sh_eff))
        else $error("wrapped source coordinate out of range");

    a_row_base: assert property (@(posedge clk) disable iff (!rst_n)
        walking |-> row_base_reg == (RB_W'(sy_reg) * RB_W'(sw_eff)))
        else $error("row base out of step with source row");

    a_p1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg && !move_p1 |=> p1_valid_reg && $stable(p1_addr_reg)
            && $stable(mem_q_reg))
        else $error("stalled read stage lost its item");

    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        issue && (cnt_reg == 6'd63) |=> (state_reg == S_IDLE) && p1_last_reg)
        else $error("tile did not end after 64 texels");

    a_no_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) && (p1_valid_reg || out_valid_reg) |-> !cmd_acc)
        else $error("command taken during tile walk");
`endif

endmodule
`default_nettype wire
